FILE: design/gcpc_pkg.sv
// Shared constants, codes and helper functions of the grid change-point clusterer.
`default_nettype none

package gcpc_pkg;

    // Default sizes of the stores.
    localparam int DEF_MAP_CELLS   = 65536;
    localparam int DEF_MAX_POINTS  = 1024;
    localparam int DEF_MAX_OBJECTS = 64;

    // Field widths of the channels.
    localparam int CELL_IDX_W = 16;
    localparam int OCC_W      = 10;
    localparam int POS_W      = 24;
    localparam int CLASS_W    = 2;
    localparam int SLOT_W     = 6;
    localparam int OBJ_TOT_W  = 7;
    localparam int PT_TOT_W   = 11;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 40;

    localparam logic [CFG_IDX_W-1:0] REG_OCC_THR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_JOIN_RSQ  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_SQ  = 3'd6;

    // Register reset values.
    localparam logic [8:0]  RST_OCC_THR   = 9'd180;
    localparam logic [12:0] RST_MAP_WIDTH = 13'd256;
    localparam logic [19:0] RST_CELL_SIZE = 20'd13107;
    localparam logic [15:0] RST_JOIN_RSQ  = 16'd9;
    localparam logic [23:0] RST_RANGE_SQ  = 24'd14400;

    // Cell class codes.
    localparam logic [CLASS_W-1:0] CLASS_STATIC  = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_DYNAMIC = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_UNKNOWN = 2'd2;

    // Squared distance width: two squares of 25-bit differences.
    localparam int DSQ_W = 50;

    // Turns a Q16 product plus a Q16 origin into whole meters, truncated toward
    // zero and saturated to the 24-bit point range.
    function automatic logic signed [POS_W-1:0] to_meters(input logic [35:0] prod,
                                                          input logic signed [39:0] org);
        logic signed [41:0] sum;
        logic signed [41:0] adj;
        logic signed [25:0] whole;
        sum   = $signed({6'b0, prod}) + $signed({{2{org[39]}}, org});
        adj   = sum + (sum[41] ? 42'sd65535 : 42'sd0);
        whole = adj[41:16];
        if (whole > 26'sd8388607) begin
            to_meters = 24'sh7FFFFF;
        end else if (whole < -26'sd8388608) begin
            to_meters = 24'sh800000;
        end else begin
            to_meters = whole[23:0];
        end
    endfunction

endpackage

`default_nettype wire

FILE: design/gcpc_dist.sv
// Squared-distance unit: registered squares of the two axis differences and their sum.
`default_nettype none

module gcpc_dist (
    input  wire logic                              aclk,
    input  wire logic signed [gcpc_pkg::POS_W-1:0] ax,
    input  wire logic signed [gcpc_pkg::POS_W-1:0] ay,
    input  wire logic signed [gcpc_pkg::POS_W-1:0] bx,
    input  wire logic signed [gcpc_pkg::POS_W-1:0] by,
    output logic [gcpc_pkg::DSQ_W-1:0]             dsq
);
    import gcpc_pkg::*;

    logic signed [POS_W:0]     dx;
    logic signed [POS_W:0]     dy;
    logic signed [2*POS_W+1:0] sqx;
    logic signed [2*POS_W+1:0] sqy;
    logic [DSQ_W-2:0]          sqx_reg;
    logic [DSQ_W-2:0]          sqy_reg;

    assign dx  = {ax[POS_W-1], ax} - {bx[POS_W-1], bx};
    assign dy  = {ay[POS_W-1], ay} - {by[POS_W-1], by};
    assign sqx = dx * dx;
    assign sqy = dy * dy;

    always_ff @(posedge aclk) begin
        sqx_reg <= sqx[DSQ_W-2:0];
        sqy_reg <= sqy[DSQ_W-2:0];
    end

    assign dsq = {1'b0, sqx_reg} + {1'b0, sqy_reg};

endmodule

`default_nettype wire

FILE: design/grid_change_point_clusterer.sv
// Top level of the grid change-point clusterer: sequencer, stores and result register.
//
//   Channel   Direction   Handshake             Payload
//   s_        in          s_valid / s_ready      cell index, occupancies, car pose, frame end
//   m_        out         m_valid / m_ready      class, slot, new/full flags, totals
//   cfg_      in          cfg_wr_en (no wait)    cfg_index, cfg_wr_data
//
// After reset a clearing pass sets every class entry to
// unknown and every point slot to empty; s_ready stays low meanwhile.
// A dynamic cell sweeps the whole point memory, read once per cycle, and
// steps through the object ids when a new object id is chosen.
// A frame end adds a second point sweep and a compaction pass over the
// listed objects.
// A finished result waits in the output register; the next beat is taken only
// once that register is empty or is being read in the same cycle.
`default_nettype none

module grid_change_point_clusterer #(
    parameter int MAP_CELLS   = gcpc_pkg::DEF_MAP_CELLS,
    parameter int MAX_POINTS  = gcpc_pkg::DEF_MAX_POINTS,
    parameter int MAX_OBJECTS = gcpc_pkg::DEF_MAX_OBJECTS
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   cfg_wr_en,
    input  wire logic [gcpc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [gcpc_pkg::CFG_DATA_W-1:0]        cfg_wr_data,
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic [gcpc_pkg::CELL_IDX_W-1:0]        s_cell_index,
    input  wire logic signed [gcpc_pkg::OCC_W-1:0]      s_current_occ,
    input  wire logic signed [gcpc_pkg::OCC_W-1:0]      s_previous_occ,
    input  wire logic signed [gcpc_pkg::POS_W-1:0]      s_car_x,
    input  wire logic signed [gcpc_pkg::POS_W-1:0]      s_car_y,
    input  wire logic                                   s_end_of_frame,
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic [gcpc_pkg::CLASS_W-1:0]                m_cell_class,
    output logic [gcpc_pkg::SLOT_W-1:0]                 m_object_slot,
    output logic                                        m_new_object,
    output logic                                        m_store_full,
    output logic [gcpc_pkg::OBJ_TOT_W-1:0]              m_object_total,
    output logic [gcpc_pkg::PT_TOT_W-1:0]               m_point_total
);
    import gcpc_pkg::*;

    // The class store wraps its address modulo MAP_CELLS, a power of two.
    localparam int AW      = $clog2(MAP_CELLS);
    localparam int PW      = $clog2(MAX_POINTS);
    localparam int OW      = $clog2(MAX_OBJECTS);
    localparam int OCW     = $clog2(MAX_OBJECTS + 1);
    localparam int PCW     = $clog2(MAX_POINTS + 1);
    localparam int SCW     = $clog2(MAX_POINTS + 2);
    localparam int CLR_LEN = (MAP_CELLS > MAX_POINTS) ? MAP_CELLS : MAX_POINTS;
    localparam int CW      = $clog2(CLR_LEN);
    localparam int PTW     = 1 + OW + 2 * POS_W;

    typedef enum logic [13:0] {
        ST_CLEAR  = 14'b00000000000001,
        ST_IDLE   = 14'b00000000000010,
        ST_CLASS  = 14'b00000000000100,
        ST_DIV    = 14'b00000000001000,
        ST_MULX   = 14'b00000000010000,
        ST_MULY   = 14'b00000000100000,
        ST_CONV   = 14'b00000001000000,
        ST_SCAN   = 14'b00000010000000,
        ST_DECIDE = 14'b00000100000000,
        ST_FINDID = 14'b00001000000000,
        ST_STORE  = 14'b00010000000000,
        ST_PRUNE  = 14'b00100000000000,
        ST_CRD    = 14'b01000000000000,
        ST_CWR    = 14'b10000000000000
    } state_t;

    // Configuration registers.
    logic [8:0]         thr_reg;
    logic [12:0]        mw_reg;
    logic [19:0]        cs_reg;
    logic signed [39:0] ox_reg;
    logic signed [39:0] oy_reg;
    logic [15:0]        jr_reg;
    logic [23:0]        rng_reg;

    // Memories.
    logic [CLASS_W-1:0] class_mem [MAP_CELLS];
    logic [PTW-1:0]     pt_mem    [MAX_POINTS];
    logic [OW-1:0]      order_mem [MAX_OBJECTS];
    logic [OW-1:0]      pos_mem   [MAX_OBJECTS];

    logic               cls_we;
    logic [AW-1:0]      cls_waddr;
    logic [CLASS_W-1:0] cls_wdata;
    logic [AW-1:0]      cls_raddr;
    logic [CLASS_W-1:0] cls_rd_reg;
    logic               pt_we;
    logic [PW-1:0]      pt_waddr;
    logic [PTW-1:0]     pt_wdata;
    logic [PW-1:0]      pt_raddr;
    logic [PTW-1:0]     pt_rd_reg;
    logic               ord_we;
    logic [OW-1:0]      ord_waddr;
    logic [OW-1:0]      ord_wdata;
    logic [OW-1:0]      ord_rd_reg;
    logic               pos_we;
    logic [OW-1:0]      pos_waddr;
    logic [OW-1:0]      pos_wdata;
    logic [OW-1:0]      pos_rd_reg;

    // Sequencer and working registers.
    state_t state_reg, state_next;
    logic [CW-1:0]           clr_reg, clr_next;
    logic [AW-1:0]           addr_reg, addr_next;
    logic [CELL_IDX_W-1:0]   idx_reg, idx_next;
    logic signed [OCC_W-1:0] cur_reg, cur_next;
    logic signed [OCC_W-1:0] prev_reg, prev_next;
    logic signed [POS_W-1:0] carx_reg, carx_next;
    logic signed [POS_W-1:0] cary_reg, cary_next;
    logic                    eof_reg, eof_next;
    logic [12:0]             rem_reg, rem_next;
    logic [15:0]             quo_reg, quo_next;
    logic [3:0]              dcnt_reg, dcnt_next;
    logic [15:0]             col_reg, col_next;
    logic [15:0]             row_reg, row_next;
    logic [35:0]             prod_reg, prod_next;
    logic signed [POS_W-1:0] px_reg, px_next;
    logic signed [POS_W-1:0] py_reg, py_next;
    logic [SCW-1:0]          scnt_reg, scnt_next;
    logic                    p1_vld_reg, p2_vld_reg;
    logic [PW-1:0]           p1_idx_reg, p2_idx_reg;
    logic                    p2_pv_reg;
    logic [OW-1:0]           p2_own_reg;
    logic                    fnd_reg, fnd_next;
    logic [OW-1:0]           bpos_reg, bpos_next;
    logic [OW-1:0]           bown_reg, bown_next;
    logic                    free_ok_reg, free_ok_next;
    logic [PW-1:0]           free_idx_reg, free_idx_next;
    logic [OW-1:0]           id_reg, id_next;
    logic [OCW-1:0]          ocnt_reg, ocnt_next;
    logic [PCW-1:0]          pcnt_reg, pcnt_next;
    logic [OCW-1:0]          ci_reg, ci_next;
    logic [OCW-1:0]          keep_reg, keep_next;
    logic [MAX_OBJECTS-1:0]  used_reg, used_next;
    logic [MAX_OBJECTS-1:0]  alive_reg, alive_next;
    logic [CLASS_W-1:0]      rcls_reg, rcls_next;
    logic [OW-1:0]           rslot_reg, rslot_next;
    logic                    rnew_reg, rnew_next;
    logic                    rfull_reg, rfull_next;
    logic                    m_valid_reg, m_valid_next;
    logic                    m_load;
    logic [CLASS_W-1:0]      m_cls_reg;
    logic [SLOT_W-1:0]       m_slot_reg;
    logic                    m_new_reg;
    logic                    m_full_reg;
    logic [OBJ_TOT_W-1:0]    m_otot_reg;
    logic [PT_TOT_W-1:0]     m_ptot_reg;

    // Combinational helpers.
    logic                         accept;
    logic                         issue;
    logic [AW+CELL_IDX_W-1:0]     idx_ext;
    logic                         cur_occ;
    logic                         prev_occ;
    logic                         prev_low;
    logic [CLASS_W-1:0]           cls_c;
    logic [13:0]                  dtrial;
    logic [15:0]                  mul_a;
    logic                         pt_v;
    logic [OW-1:0]                pt_own;
    logic signed [POS_W-1:0]      pt_x;
    logic signed [POS_W-1:0]      pt_y;
    logic signed [POS_W-1:0]      ref_x;
    logic signed [POS_W-1:0]      ref_y;
    logic [DSQ_W-1:0]             dsq;
    logic [OW-1:0]                own_sel;

    // A new beat is taken only when the output register will be free by the
    // time this cell finishes, so a waiting result is never overwritten.
    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign idx_ext = {{AW{1'b0}}, s_cell_index};
    assign cls_raddr = idx_ext[AW-1:0];

    // Configuration writes; unlisted indexes fall through.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= RST_OCC_THR;
            mw_reg  <= RST_MAP_WIDTH;
            cs_reg  <= RST_CELL_SIZE;
            ox_reg  <= '0;
            oy_reg  <= '0;
            jr_reg  <= RST_JOIN_RSQ;
            rng_reg <= RST_RANGE_SQ;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_OCC_THR:   thr_reg <= cfg_wr_data[8:0];
                REG_MAP_WIDTH: mw_reg  <= cfg_wr_data[12:0];
                REG_CELL_SIZE: cs_reg  <= cfg_wr_data[19:0];
                REG_ORIGIN_X:  ox_reg  <= $signed(cfg_wr_data);
                REG_ORIGIN_Y:  oy_reg  <= $signed(cfg_wr_data);
                REG_JOIN_RSQ:  jr_reg  <= cfg_wr_data[15:0];
                REG_RANGE_SQ:  rng_reg <= cfg_wr_data[23:0];
                default: begin
                end
            endcase
        end
    end

    // Memories, each with one write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (cls_we) begin
            class_mem[cls_waddr] <= cls_wdata;
        end
        cls_rd_reg <= class_mem[cls_raddr];
    end

    always_ff @(posedge aclk) begin
        if (pt_we) begin
            pt_mem[pt_waddr] <= pt_wdata;
        end
        pt_rd_reg <= pt_mem[pt_raddr];
    end

    always_ff @(posedge aclk) begin
        if (ord_we) begin
            order_mem[ord_waddr] <= ord_wdata;
        end
        ord_rd_reg <= order_mem[ci_reg[OW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (pos_we) begin
            pos_mem[pos_waddr] <= pos_wdata;
        end
        pos_rd_reg <= pos_mem[pt_own];
    end

    // Fields of the point word that comes out of the memory.
    assign pt_v   = pt_rd_reg[PTW-1];
    assign pt_own = pt_rd_reg[PTW-2 -: OW];
    assign pt_x   = pt_rd_reg[2*POS_W-1:POS_W];
    assign pt_y   = pt_rd_reg[POS_W-1:0];

    // The join sweep measures from the new point, the prune sweep from the car.
    assign ref_x = (state_reg == ST_SCAN) ? px_reg : carx_reg;
    assign ref_y = (state_reg == ST_SCAN) ? py_reg : cary_reg;

    gcpc_dist u_dist (
        .aclk (aclk),
        .ax   (pt_x),
        .ay   (pt_y),
        .bx   (ref_x),
        .by   (ref_y),
        .dsq  (dsq)
    );

    // Occupied means threshold <= occupancy <= 1.0.
    assign cur_occ  = ($signed({cur_reg[OCC_W-1], cur_reg}) >= $signed({2'b00, thr_reg}))
                      && (cur_reg <= 10'sd256);
    assign prev_occ = ($signed({prev_reg[OCC_W-1], prev_reg}) >= $signed({2'b00, thr_reg}))
                      && (prev_reg <= 10'sd256);
    assign prev_low = $signed({prev_reg[OCC_W-1], prev_reg}) < $signed({2'b00, thr_reg});

    always_comb begin
        if (!cur_occ) begin
            cls_c = CLASS_UNKNOWN;
        end else if (prev_occ) begin
            cls_c = CLASS_STATIC;
        end else if (prev_low || cls_rd_reg == CLASS_DYNAMIC) begin
            cls_c = CLASS_DYNAMIC;
        end else begin
            cls_c = CLASS_UNKNOWN;
        end
    end

    assign dtrial  = {rem_reg, quo_reg[15]};
    assign mul_a   = (state_reg == ST_MULX) ? col_reg : row_reg;
    assign issue   = (state_reg == ST_SCAN || state_reg == ST_PRUNE)
                     && (scnt_reg < SCW'(MAX_POINTS));
    assign pt_raddr = scnt_reg[PW-1:0];
    assign own_sel = rnew_reg ? id_reg : bown_reg;

    always_comb begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        addr_next     = addr_reg;
        idx_next      = idx_reg;
        cur_next      = cur_reg;
        prev_next     = prev_reg;
        carx_next     = carx_reg;
        cary_next     = cary_reg;
        eof_next      = eof_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        dcnt_next     = dcnt_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        prod_next     = prod_reg;
        px_next       = px_reg;
        py_next       = py_reg;
        scnt_next     = scnt_reg;
        fnd_next      = fnd_reg;
        bpos_next     = bpos_reg;
        bown_next     = bown_reg;
        free_ok_next  = free_ok_reg;
        free_idx_next = free_idx_reg;
        id_next       = id_reg;
        ocnt_next     = ocnt_reg;
        pcnt_next     = pcnt_reg;
        ci_next       = ci_reg;
        keep_next     = keep_reg;
        used_next     = used_reg;
        alive_next    = alive_reg;
        rcls_next     = rcls_reg;
        rslot_next    = rslot_reg;
        rnew_next     = rnew_reg;
        rfull_next    = rfull_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_load        = 1'b0;
        cls_we        = 1'b0;
        cls_waddr     = addr_reg;
        cls_wdata     = cls_c;
        pt_we         = 1'b0;
        pt_waddr      = free_idx_reg;
        pt_wdata      = {1'b1, own_sel, px_reg, py_reg};
        ord_we        = 1'b0;
        ord_waddr     = ocnt_reg[OW-1:0];
        ord_wdata     = id_reg;
        pos_we        = 1'b0;
        pos_waddr     = id_reg;
        pos_wdata     = ocnt_reg[OW-1:0];

        case (state_reg)
            ST_CLEAR: begin
                if (clr_reg <= CW'(MAP_CELLS - 1)) begin
                    cls_we    = 1'b1;
                    cls_waddr = clr_reg[AW-1:0];
                    cls_wdata = CLASS_UNKNOWN;
                end
                if (clr_reg <= CW'(MAX_POINTS - 1)) begin
                    pt_we    = 1'b1;
                    pt_waddr = clr_reg[PW-1:0];
                    pt_wdata = '0;
                end
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CW'(CLR_LEN - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    addr_next    = cls_raddr;
                    idx_next     = s_cell_index;
                    cur_next     = s_current_occ;
                    prev_next    = s_previous_occ;
                    carx_next    = s_car_x;
                    cary_next    = s_car_y;
                    eof_next     = s_end_of_frame;
                    fnd_next     = 1'b0;
                    free_ok_next = 1'b0;
                    alive_next   = '0;
                    rslot_next   = '0;
                    rnew_next    = 1'b0;
                    rfull_next   = 1'b0;
                    scnt_next    = '0;
                    state_next   = ST_CLASS;
                end
            end
            ST_CLASS: begin
                cls_we    = 1'b1;
                rcls_next = cls_c;
                if (cls_c == CLASS_DYNAMIC) begin
                    if (mw_reg == 13'd0) begin
                        col_next   = idx_reg;
                        row_next   = '0;
                        state_next = ST_MULX;
                    end else begin
                        rem_next   = '0;
                        quo_next   = idx_reg;
                        dcnt_next  = '0;
                        state_next = ST_DIV;
                    end
                end else if (eof_reg) begin
                    state_next = ST_PRUNE;
                end else begin
                    state_next = ST_IDLE;
                    m_load     = 1'b1;
                end
            end
            ST_DIV: begin
                // Restoring division, one quotient bit per cycle.
                if (dtrial >= {1'b0, mw_reg}) begin
                    rem_next = 13'(dtrial - {1'b0, mw_reg});
                    quo_next = {quo_reg[14:0], 1'b1};
                end else begin
                    rem_next = dtrial[12:0];
                    quo_next = {quo_reg[14:0], 1'b0};
                end
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == 4'd15) begin
                    col_next   = {3'b000, rem_next};
                    row_next   = quo_next;
                    state_next = ST_MULX;
                end
            end
            ST_MULX: begin
                prod_next  = mul_a * cs_reg;
                state_next = ST_MULY;
            end
            ST_MULY: begin
                prod_next  = mul_a * cs_reg;
                px_next    = to_meters(prod_reg, ox_reg);
                state_next = ST_CONV;
            end
            ST_CONV: begin
                py_next    = to_meters(prod_reg, oy_reg);
                scnt_next  = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                // The count runs two past the last read so the pipeline drains.
                if (scnt_reg != SCW'(MAX_POINTS + 1)) begin
                    scnt_next = scnt_reg + 1'b1;
                end
                if (p2_vld_reg) begin
                    if (!p2_pv_reg && !free_ok_reg) begin
                        free_ok_next  = 1'b1;
                        free_idx_next = p2_idx_reg;
                    end
                    // A neighbor counts only if it is not at the very same spot.
                    if (p2_pv_reg && dsq != '0 && dsq <= DSQ_W'(jr_reg)
                        && (!fnd_reg || pos_rd_reg < bpos_reg)) begin
                        fnd_next  = 1'b1;
                        bpos_next = pos_rd_reg;
                        bown_next = p2_own_reg;
                    end
                end
                if (scnt_reg == SCW'(MAX_POINTS + 1)) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (fnd_reg && free_ok_reg) begin
                    rslot_next = bpos_reg;
                    state_next = ST_STORE;
                end else if (fnd_reg || !free_ok_reg || ocnt_reg >= OCW'(MAX_OBJECTS)) begin
                    rfull_next = 1'b1;
                    scnt_next  = '0;
                    if (eof_reg) begin
                        state_next = ST_PRUNE;
                    end else begin
                        state_next = ST_IDLE;
                        m_load     = 1'b1;
                    end
                end else begin
                    id_next    = '0;
                    state_next = ST_FINDID;
                end
            end
            ST_FINDID: begin
                // Lowest object id not in the list.
                if (!used_reg[id_reg]) begin
                    rnew_next  = 1'b1;
                    state_next = ST_STORE;
                end else begin
                    id_next = id_reg + 1'b1;
                end
            end
            ST_STORE: begin
                pt_we     = 1'b1;
                pcnt_next = pcnt_reg + 1'b1;
                if (rnew_reg) begin
                    ord_we           = 1'b1;
                    pos_we           = 1'b1;
                    used_next[id_reg] = 1'b1;
                    rslot_next       = ocnt_reg[OW-1:0];
                    ocnt_next        = ocnt_reg + 1'b1;
                end
                scnt_next = '0;
                if (eof_reg) begin
                    state_next = ST_PRUNE;
                end else begin
                    state_next = ST_IDLE;
                    m_load     = 1'b1;
                end
            end
            ST_PRUNE: begin
                if (scnt_reg != SCW'(MAX_POINTS + 1)) begin
                    scnt_next = scnt_reg + 1'b1;
                end
                if (p2_vld_reg && p2_pv_reg) begin
                    if (dsq >= DSQ_W'(rng_reg)) begin
                        pt_we     = 1'b1;
                        pt_waddr  = p2_idx_reg;
                        pt_wdata  = '0;
                        pcnt_next = pcnt_reg - 1'b1;
                    end else begin
                        alive_next[p2_own_reg] = 1'b1;
                    end
                end
                if (scnt_reg == SCW'(MAX_POINTS + 1)) begin
                    ci_next    = '0;
                    keep_next  = '0;
                    state_next = ST_CRD;
                end
            end
            ST_CRD: begin
                if (ci_reg == ocnt_reg) begin
                    ocnt_next  = keep_reg;
                    state_next = ST_IDLE;
                    m_load     = 1'b1;
                end else begin
                    state_next = ST_CWR;
                end
            end
            ST_CWR: begin
                // Surviving objects slide down, keeping their order.
                if (alive_reg[ord_rd_reg]) begin
                    ord_we    = 1'b1;
                    ord_waddr = keep_reg[OW-1:0];
                    ord_wdata = ord_rd_reg;
                    pos_we    = 1'b1;
                    pos_waddr = ord_rd_reg;
                    pos_wdata = keep_reg[OW-1:0];
                    keep_next = keep_reg + 1'b1;
                end else begin
                    used_next[ord_rd_reg] = 1'b0;
                end
                ci_next    = ci_reg + 1'b1;
                state_next = ST_CRD;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // The output register is known to be free whenever the sequencer finishes.
        if (m_load) begin
            m_valid_next = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            scnt_reg    <= '0;
            p1_vld_reg  <= 1'b0;
            p2_vld_reg  <= 1'b0;
            ocnt_reg    <= '0;
            pcnt_reg    <= '0;
            used_reg    <= '0;
            alive_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            scnt_reg    <= scnt_next;
            p1_vld_reg  <= issue;
            p2_vld_reg  <= p1_vld_reg;
            ocnt_reg    <= ocnt_next;
            pcnt_reg    <= pcnt_next;
            used_reg    <= used_next;
            alive_reg   <= alive_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload and working registers.
    always_ff @(posedge aclk) begin
        addr_reg     <= addr_next;
        idx_reg      <= idx_next;
        cur_reg      <= cur_next;
        prev_reg     <= prev_next;
        carx_reg     <= carx_next;
        cary_reg     <= cary_next;
        eof_reg      <= eof_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        dcnt_reg     <= dcnt_next;
        col_reg      <= col_next;
        row_reg      <= row_next;
        prod_reg     <= prod_next;
        px_reg       <= px_next;
        py_reg       <= py_next;
        p1_idx_reg   <= pt_raddr;
        p2_idx_reg   <= p1_idx_reg;
        p2_pv_reg    <= pt_v;
        p2_own_reg   <= pt_own;
        fnd_reg      <= fnd_next;
        bpos_reg     <= bpos_next;
        bown_reg     <= bown_next;
        free_ok_reg  <= free_ok_next;
        free_idx_reg <= free_idx_next;
        id_reg       <= id_next;
        ci_reg       <= ci_next;
        keep_reg     <= keep_next;
        rcls_reg     <= rcls_next;
        rslot_reg    <= rslot_next;
        rnew_reg     <= rnew_next;
        rfull_reg    <= rfull_next;
        if (m_load) begin
            m_cls_reg  <= rcls_next;
            m_slot_reg <= SLOT_W'(rslot_next);
            m_new_reg  <= rnew_next;
            m_full_reg <= rfull_next;
            m_otot_reg <= OBJ_TOT_W'(ocnt_next);
            m_ptot_reg <= PT_TOT_W'(pcnt_next);
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_cell_class   = m_cls_reg;
    assign m_object_slot  = m_slot_reg;
    assign m_new_object   = m_new_reg;
    assign m_store_full   = m_full_reg;
    assign m_object_total = m_otot_reg;
    assign m_point_total  = m_ptot_reg;

endmodule

`default_nettype wire

FILE: design/gcpc_checker.sv
// Port-level checks of the grid change-point clusterer and their binding.
`default_nettype none

module gcpc_checker (
    input wire logic                                   aclk,
    input wire logic                                   aresetn,
    input wire logic                                   s_valid,
    input wire logic                                   s_ready,
    input wire logic                                   m_valid,
    input wire logic                                   m_ready,
    input wire logic [gcpc_pkg::CLASS_W-1:0]           m_cell_class,
    input wire logic [gcpc_pkg::SLOT_W-1:0]            m_object_slot,
    input wire logic                                   m_new_object,
    input wire logic                                   m_store_full,
    input wire logic [gcpc_pkg::OBJ_TOT_W-1:0]         m_object_total,
    input wire logic [gcpc_pkg::PT_TOT_W-1:0]          m_point_total
);
    import gcpc_pkg::*;

    // A taken beat keeps the block busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("s_ready stayed high after an accepted beat");

    // A result waiting on the output side holds still.
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_cell_class)
            && $stable(m_object_slot) && $stable(m_object_total)
            && $stable(m_point_total)))
        else $error("output beat changed while stalled");

    // A non-dynamic cell reports no slot, no new object and no full store.
    a_non_dynamic_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_cell_class != CLASS_DYNAMIC) |->
            (m_object_slot == '0 && !m_new_object && !m_store_full))
        else $error("non-dynamic cell reported object activity");

    // A dropped point neither starts an object nor names a slot.
    a_full_drops: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_store_full) |-> (!m_new_object && m_object_slot == '0))
        else $error("dropped point reported a slot or a new object");

endmodule

bind grid_change_point_clusterer gcpc_checker u_gcpc_checker (.*);

`default_nettype wire
